// File: rtl/stws_pkg.sv
// Package for the sum-tree weighted sampler: beat structs, micro-op codes,
// sequencer status bits and the read-only microprogram. No dependencies.
package stws_pkg;

    localparam int STEP_W = 5;

    localparam logic [STEP_W-1:0] ST_CLR    = 5'd0;
    localparam logic [STEP_W-1:0] ST_IDLE   = 5'd1;
    localparam logic [STEP_W-1:0] ST_U_RDW  = 5'd2;
    localparam logic [STEP_W-1:0] ST_U_LSUM = 5'd3;
    localparam logic [STEP_W-1:0] ST_U_ASC  = 5'd4;
    localparam logic [STEP_W-1:0] ST_U_RDT  = 5'd5;
    localparam logic [STEP_W-1:0] ST_U_TOT  = 5'd6;
    localparam logic [STEP_W-1:0] ST_EMIT   = 5'd7;
    localparam logic [STEP_W-1:0] ST_S_RDT  = 5'd8;
    localparam logic [STEP_W-1:0] ST_S_TOT  = 5'd9;
    localparam logic [STEP_W-1:0] ST_S_MLO  = 5'd10;
    localparam logic [STEP_W-1:0] ST_S_MHI  = 5'd11;
    localparam logic [STEP_W-1:0] ST_S_TADD = 5'd12;
    localparam logic [STEP_W-1:0] ST_S_DRD  = 5'd13;
    localparam logic [STEP_W-1:0] ST_S_DCMP = 5'd14;
    localparam logic [STEP_W-1:0] ST_S_LRD  = 5'd15;
    localparam logic [STEP_W-1:0] ST_S_LSEL = 5'd16;

    localparam logic       REQ_SAMPLE = 1'b1;
    localparam logic [1:0] SUB_MAX    = 2'd2;

    typedef struct packed {
        logic        req_type;
        logic [9:0]  leaf_index;
        logic [1:0]  sub_index;
        logic [23:0] new_weight;
        logic [31:0] random_fraction;
    } t_in_item;

    typedef struct packed {
        logic [9:0]  chosen_leaf;
        logic [1:0]  chosen_sub;
        logic [35:0] total_weight;
        logic        empty_flag;
    } t_out_item;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_CLEAR,
        OP_ACCEPT,
        OP_WRD,
        OP_LSUM,
        OP_ASC,
        OP_RDROOT,
        OP_TOTAL,
        OP_EMIT,
        OP_MLO,
        OP_MHI,
        OP_TADD,
        OP_DRD,
        OP_DCMP,
        OP_LRD,
        OP_LSEL
    } t_uop;

    typedef enum logic [3:0] {
        C_NEXT,
        C_ALWAYS,
        C_CLR_MORE,
        C_SAMPLE,
        C_BAD_UPD,
        C_NOT_TOP,
        C_EMPTY,
        C_NOT_LEAF,
        C_LEAF_OOR
    } t_cond;

    typedef struct packed {
        t_uop              op;
        t_cond             cond;
        logic [STEP_W-1:0] tgt;
    } t_uword;

    typedef struct packed {
        logic hold;
        logic clr_more;
        logic sample;
        logic bad_upd;
        logic not_top;
        logic empty;
        logic not_leaf;
        logic leaf_oor;
    } t_stat;

    // The microprogram. A step jumps to tgt when its condition holds,
    // otherwise it falls through to the following step.
    function automatic t_uword ucode(input logic [STEP_W-1:0] step);
        t_uword w;
        case (step)
            ST_CLR:    w = '{op: OP_CLEAR,  cond: C_CLR_MORE, tgt: ST_CLR};
            ST_IDLE:   w = '{op: OP_ACCEPT, cond: C_SAMPLE,   tgt: ST_S_RDT};
            ST_U_RDW:  w = '{op: OP_WRD,    cond: C_BAD_UPD,  tgt: ST_U_RDT};
            ST_U_LSUM: w = '{op: OP_LSUM,   cond: C_NEXT,     tgt: ST_IDLE};
            ST_U_ASC:  w = '{op: OP_ASC,    cond: C_NOT_TOP,  tgt: ST_U_ASC};
            ST_U_RDT:  w = '{op: OP_RDROOT, cond: C_NEXT,     tgt: ST_IDLE};
            ST_U_TOT:  w = '{op: OP_TOTAL,  cond: C_NEXT,     tgt: ST_IDLE};
            ST_EMIT:   w = '{op: OP_EMIT,   cond: C_ALWAYS,   tgt: ST_IDLE};
            ST_S_RDT:  w = '{op: OP_RDROOT, cond: C_NEXT,     tgt: ST_IDLE};
            ST_S_TOT:  w = '{op: OP_TOTAL,  cond: C_EMPTY,    tgt: ST_EMIT};
            ST_S_MLO:  w = '{op: OP_MLO,    cond: C_NEXT,     tgt: ST_IDLE};
            ST_S_MHI:  w = '{op: OP_MHI,    cond: C_NEXT,     tgt: ST_IDLE};
            ST_S_TADD: w = '{op: OP_TADD,   cond: C_NEXT,     tgt: ST_IDLE};
            ST_S_DRD:  w = '{op: OP_DRD,    cond: C_NEXT,     tgt: ST_IDLE};
            ST_S_DCMP: w = '{op: OP_DCMP,   cond: C_NOT_LEAF, tgt: ST_S_DRD};
            ST_S_LRD:  w = '{op: OP_LRD,    cond: C_LEAF_OOR, tgt: ST_EMIT};
            ST_S_LSEL: w = '{op: OP_LSEL,   cond: C_ALWAYS,   tgt: ST_EMIT};
            default:   w = '{op: OP_NOP,    cond: C_ALWAYS,   tgt: ST_IDLE};
        endcase
        return w;
    endfunction

endpackage

// File: rtl/stws_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module stws_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;
endmodule

// File: rtl/stws_useq.sv
// Microcode sequencer: step counter, program table and jump logic.
// Depends on stws_pkg.
module stws_useq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  stws_pkg::t_stat i_stat,
    output stws_pkg::t_uword o_uword
);
    import stws_pkg::*;

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    t_uword            uword;
    logic              hit;

    assign uword = ucode(r_step);

    always_comb begin
        case (uword.cond)
            C_NEXT:     hit = 1'b0;
            C_ALWAYS:   hit = 1'b1;
            C_CLR_MORE: hit = i_stat.clr_more;
            C_SAMPLE:   hit = i_stat.sample;
            C_BAD_UPD:  hit = i_stat.bad_upd;
            C_NOT_TOP:  hit = i_stat.not_top;
            C_EMPTY:    hit = i_stat.empty;
            C_NOT_LEAF: hit = i_stat.not_leaf;
            C_LEAF_OOR: hit = i_stat.leaf_oor;
            default:    hit = 1'b1;
        endcase
        if (i_stat.hold) begin
            n_step = r_step;
        end else if (hit) begin
            n_step = uword.tgt;
        end else begin
            n_step = r_step + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_CLR;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_uword = uword;
endmodule

// File: rtl/stws_dpath.sv
// Datapath of the sampler: weight and partial-sum memories, the scaling
// multiplier, descent compare and the output register. Uses stws_pkg, stws_ram.
module stws_dpath #(
    parameter int LEAF_COUNT  = 1024,
    parameter int TREE_DEPTH  = 10,
    parameter int WEIGHT_BITS = 24
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  stws_pkg::t_uword    i_uword,
    output stws_pkg::t_stat     o_stat,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  stws_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output stws_pkg::t_out_item o_out_data
);
    import stws_pkg::*;

    localparam int TREE_LEAVES = 1 << TREE_DEPTH;
    localparam int NODE_COUNT  = 2 * TREE_LEAVES - 1;
    localparam int LEAF_BASE   = TREE_LEAVES - 1;
    localparam int WDEPTH      = (LEAF_COUNT < TREE_LEAVES) ? LEAF_COUNT : TREE_LEAVES;
    localparam int NW          = TREE_DEPTH + 1;
    localparam int WAW         = $clog2(WDEPTH);
    localparam int SW          = WEIGHT_BITS + 2 + TREE_DEPTH;

    function automatic logic [NW-1:0] sibling(input logic [NW-1:0] n);
        logic [NW-1:0] s;
        s = n[0] ? n + 1'b1 : n - 1'b1;
        return s;
    endfunction

    t_uop op;

    t_in_item       r_item;
    logic [NW-1:0]  r_node;
    logic [SW-1:0]  r_acc;
    logic [SW-1:0]  r_total;
    logic [SW-1:0]  r_tgt;
    logic [63:0]    r_prod;
    logic [9:0]     r_leaf;
    logic [1:0]     r_sub;
    logic           r_ovalid;
    t_out_item      r_out;

    logic [SW-1:0]          tree_rd;
    logic                   tree_we;
    logic [NW-1:0]          tree_waddr;
    logic [SW-1:0]          tree_wdata;
    logic [NW-1:0]          tree_raddr;
    logic [WEIGHT_BITS-1:0] wt_rd [3];
    logic [2:0]             wt_we;
    logic [WAW-1:0]         wt_waddr;
    logic [WEIGHT_BITS-1:0] wt_wdata;
    logic [WAW-1:0]         wt_raddr;

    logic [31:0]            nw32;
    logic [WEIGHT_BITS-1:0] new_w;
    logic [31:0]            leaf32;
    logic [31:0]            leaf_node32;
    logic [NW-1:0]          leaf_node;
    logic                   upd_bad;
    logic [WEIGHT_BITS-1:0] ws [3];
    logic [SW-1:0]          lsum;
    logic [NW-1:0]          parent;
    logic [SW-1:0]          asc_sum;
    logic [NW-1:0]          lchild;
    logic [NW-1:0]          rchild;
    logic                   go_right;
    logic [NW-1:0]          d_next;
    logic [NW-1:0]          g;
    logic [31:0]            g32;
    logic [63:0]            tot64;
    logic [31:0]            mul_b;
    logic [63:0]            mul;
    logic                   ge0;
    logic                   ge1;
    logic [SW-1:0]          t1;
    logic [1:0]             leaf_sub;
    logic                   emit_hold;

    assign op = i_uword.op;

    // Update path helpers
    assign nw32        = 32'(r_item.new_weight);
    assign new_w       = nw32[WEIGHT_BITS-1:0];
    assign leaf32      = 32'(r_item.leaf_index);
    assign upd_bad     = (leaf32 >= WDEPTH) || (r_item.sub_index > SUB_MAX);
    assign leaf_node32 = 32'(LEAF_BASE) + leaf32;
    assign leaf_node   = leaf_node32[NW-1:0];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ws[i] = (32'(r_item.sub_index) == i) ? new_w : wt_rd[i];
        end
        lsum = SW'(ws[0]) + SW'(ws[1]) + SW'(ws[2]);
    end

    assign parent  = (r_node - 1'b1) >> 1;
    assign asc_sum = r_acc + tree_rd;

    // Descent helpers: r_node holds the current internal node
    assign lchild   = {r_node[NW-2:0], 1'b1};
    assign rchild   = lchild + 1'b1;
    assign go_right = r_tgt >= tree_rd;
    assign d_next   = go_right ? rchild : lchild;
    assign g        = r_node - NW'(LEAF_BASE);
    assign g32      = 32'(g);

    // The 32 x N scale is split into two 32 x 32 products on one multiplier
    assign tot64 = 64'(r_total);
    assign mul_b = (op == OP_MHI) ? tot64[63:32] : tot64[31:0];
    assign mul   = {32'd0, r_item.random_fraction} * {32'd0, mul_b};

    // Walk across the leaf's three weights; the last one takes the remainder
    assign ge0 = r_tgt >= SW'(wt_rd[0]);
    assign t1  = r_tgt - SW'(wt_rd[0]);
    assign ge1 = t1 >= SW'(wt_rd[1]);

    always_comb begin
        if (!ge0) begin
            leaf_sub = 2'd0;
        end else if (!ge1) begin
            leaf_sub = 2'd1;
        end else begin
            leaf_sub = SUB_MAX;
        end
    end

    // Memory port control
    always_comb begin
        tree_we    = 1'b0;
        tree_waddr = r_node;
        tree_wdata = '0;
        tree_raddr = '0;
        wt_we      = '0;
        wt_waddr   = leaf32[WAW-1:0];
        wt_wdata   = new_w;
        wt_raddr   = leaf32[WAW-1:0];
        case (op)
            OP_CLEAR: begin
                tree_we  = 1'b1;
                wt_wdata = '0;
                wt_waddr = r_node[WAW-1:0];
                if (32'(r_node) < WDEPTH) begin
                    wt_we = 3'b111;
                end
            end
            OP_LSUM: begin
                tree_we    = 1'b1;
                tree_waddr = leaf_node;
                tree_wdata = lsum;
                tree_raddr = sibling(leaf_node);
                for (int i = 0; i < 3; i++) begin
                    wt_we[i] = (32'(r_item.sub_index) == i);
                end
            end
            OP_ASC: begin
                tree_we    = 1'b1;
                tree_waddr = parent;
                tree_wdata = asc_sum;
                tree_raddr = (parent == '0) ? '0 : sibling(parent);
            end
            OP_DRD: begin
                tree_raddr = lchild;
            end
            OP_LRD: begin
                wt_raddr = g[WAW-1:0];
            end
            default: begin
                tree_raddr = '0;
            end
        endcase
    end

    stws_ram #(.WIDTH(SW), .DEPTH(NODE_COUNT)) u_tree (
        .i_clk   (i_clk),
        .i_we    (tree_we),
        .i_waddr (tree_waddr),
        .i_wdata (tree_wdata),
        .i_raddr (tree_raddr),
        .o_rdata (tree_rd)
    );

    for (genvar k = 0; k < 3; k++) begin : g_wt
        stws_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(WDEPTH)) u_wt (
            .i_clk   (i_clk),
            .i_we    (wt_we[k]),
            .i_waddr (wt_waddr),
            .i_wdata (wt_wdata),
            .i_raddr (wt_raddr),
            .o_rdata (wt_rd[k])
        );
    end

    // Status for the sequencer
    assign emit_hold = r_ovalid && i_out_stall;

    always_comb begin
        o_stat.hold     = ((op == OP_ACCEPT) && !i_in_valid) || ((op == OP_EMIT) && emit_hold);
        o_stat.clr_more = r_node != NW'(NODE_COUNT - 1);
        o_stat.sample   = i_in_data.req_type == REQ_SAMPLE;
        o_stat.bad_upd  = upd_bad;
        o_stat.not_top  = parent != '0;
        o_stat.empty    = tree_rd == '0;
        o_stat.not_leaf = d_next < NW'(LEAF_BASE);
        o_stat.leaf_oor = g32 >= WDEPTH;
    end

    // Control registers; r_node doubles as the clearing address after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            case (op)
                OP_CLEAR: r_node <= r_node + 1'b1;
                OP_LSUM:  r_node <= leaf_node;
                OP_ASC:   r_node <= parent;
                OP_TADD:  r_node <= '0;
                OP_DCMP:  r_node <= d_next;
                default:  r_node <= r_node;
            endcase
            if ((op == OP_EMIT) && !emit_hold) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        case (op)
            OP_ACCEPT: begin
                if (i_in_valid) begin
                    r_item <= i_in_data;
                end
            end
            OP_LSUM: r_acc <= lsum;
            OP_ASC:  r_acc <= asc_sum;
            OP_TOTAL: begin
                r_total <= tree_rd;
                r_leaf  <= '0;
                r_sub   <= '0;
            end
            OP_MLO: r_prod <= mul;
            OP_MHI: begin
                r_tgt  <= SW'(r_prod[63:32]);
                r_prod <= mul;
            end
            OP_TADD: r_tgt <= r_tgt + SW'(r_prod);
            OP_DCMP: begin
                if (go_right) begin
                    r_tgt <= r_tgt - tree_rd;
                end
            end
            OP_LSEL: begin
                r_leaf <= g32[9:0];
                r_sub  <= leaf_sub;
            end
            OP_EMIT: begin
                if (!emit_hold) begin
                    r_out.chosen_leaf  <= r_leaf;
                    r_out.chosen_sub   <= r_sub;
                    r_out.total_weight <= tot64[35:0];
                    r_out.empty_flag   <= (r_total == '0);
                end
            end
            default: begin
                r_acc <= r_acc;
            end
        endcase
    end

    assign o_in_stall  = op != OP_ACCEPT;
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;
endmodule

// File: rtl/sum_tree_weighted_sampler_top.sv
// Top level of the sum-tree weighted sampler: microcode sequencer and datapath.
// Depends on stws_pkg, stws_useq, stws_dpath (and stws_ram below it).
//
// Usage: one input channel (i_in_valid / o_in_stall / i_in_data) carries
// update and sample requests; one output channel (o_out_valid / i_out_stall /
// o_out_data) returns exactly one result beat per request, in order.
// A beat moves on a clock edge where valid is high and stall is low.
// Requests are worked one at a time by a microprogrammed sequencer over a
// partial-sum memory with one write and one read port; the program walks
// the TREE_DEPTH (D) levels of the tree. An update writes one partial sum
// per level; a sample reads the left child and compares, per level; a
// sample on an empty tree goes straight to the result. After reset the
// block clears both memories, one node per cycle, over all 2^(D+1) - 1
// tree nodes (2047 at the defaults); o_in_stall stays high meanwhile.
// The result sits in an output register: a stalled receiver holds it there,
// the next request is still accepted, and the sequencer waits only when a
// second result is ready before the first has gone.
module sum_tree_weighted_sampler_top #(
    parameter int LEAF_COUNT  = 1024,
    parameter int TREE_DEPTH  = 10,
    parameter int WEIGHT_BITS = 24
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  stws_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output stws_pkg::t_out_item o_out_data
);
    import stws_pkg::*;

    t_uword uword;
    t_stat  stat;

    stws_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_uword (uword)
    );

    stws_dpath #(
        .LEAF_COUNT  (LEAF_COUNT),
        .TREE_DEPTH  (TREE_DEPTH),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_uword     (uword),
        .o_stat      (stat),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // Once a request is taken, no further one is taken until its program ends.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second request accepted while one is in progress");

    // A result appears only from the emit step of the program.
    a_out_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(uword.op == OP_EMIT))
        else $error("result raised outside the emit step");

    // Nothing leaves the block while the memories are being cleared.
    a_quiet_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (uword.op == OP_CLEAR) |-> (!o_out_valid && o_in_stall))
        else $error("handshake active during the clearing pass");
endmodule
